[hdl/msld_pkg.sv]
// ----------------------------------------------------------------------------
// msld_pkg
// Shared types and constants of the sync-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package msld_pkg;

  localparam int WINDOW_BYTES = 8;
  localparam int LEN_BYTES    = 4;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ABORT   = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;

  localparam logic [1:0] CFG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH   = 2'd1;

  localparam logic [30:0] MAX_LENGTH_RESET = 31'd65536;

  typedef struct packed {
    logic        valid;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic        last_of_frame;
    logic [31:0] frame_length;
  } result_t;

endpackage

[hdl/msld_if.sv]
// ----------------------------------------------------------------------------
// msld_if
// Channel interfaces: received bytes, result words and register writes.
// ----------------------------------------------------------------------------
interface msld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface msld_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  event_res;
  logic        [7:0]  data_byte;
  logic               last_of_frame;
  logic signed [31:0] frame_length;

  modport source (output valid, output event_res, output data_byte,
                  output last_of_frame, output frame_length, input ready);
  modport sink (input valid, input event_res, input data_byte,
                input last_of_frame, input frame_length, output ready);
endinterface

interface msld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/msld_sync_cell.sv]
// ----------------------------------------------------------------------------
// msld_sync_cell
// One byte of the sliding window: holds a byte, passes it on, compares the
// incoming byte with its byte of the sync pattern.
// ----------------------------------------------------------------------------
module msld_sync_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic [7:0] pattern_byte,
  output logic [7:0] byte_out,
  output logic       match
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign match    = (byte_in == pattern_byte);

endmodule

[hdl/msld_ctrl.sv]
// ----------------------------------------------------------------------------
// msld_ctrl
// Phase sequencer: hunt, length collection and payload, with length checks.
// ----------------------------------------------------------------------------
module msld_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 hit,
  input  logic [30:0]          max_frame_length,
  output msld_pkg::result_t    res
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] length_word;
  logic [31:0] length_word_next;
  logic [30:0] byte_position;
  logic [30:0] byte_position_next;
  logic [30:0] pos_inc;
  msld_pkg::result_t res_next;

  assign pos_inc = byte_position + 31'd1;

  always_comb begin
    phase_next         = phase;
    length_word_next   = length_word;
    byte_position_next = byte_position;
    res_next           = '0;
    unique case (phase)
      PH_LEN: begin
        if (hit) begin
          byte_position_next = 31'd0;
        end else begin
          for (int k = 0; k < msld_pkg::LEN_BYTES; k++) begin
            if (byte_position[1:0] == 2'(k)) begin
              length_word_next[8*k +: 8] = rx_byte;
            end
          end
          byte_position_next = pos_inc;
          if (pos_inc >= 31'(msld_pkg::LEN_BYTES)) begin
            if (length_word_next[31] || (length_word_next == 32'd0) ||
                (length_word_next[30:0] > max_frame_length)) begin
              phase_next             = PH_HUNT;
              res_next.valid         = 1'b1;
              res_next.event_res     = msld_pkg::EV_REJECT;
              res_next.frame_length  = length_word_next;
            end else begin
              phase_next         = PH_DATA;
              byte_position_next = 31'd0;
            end
          end
        end
      end
      PH_DATA: begin
        res_next.valid        = 1'b1;
        res_next.frame_length = length_word;
        if (hit) begin
          phase_next         = PH_LEN;
          byte_position_next = 31'd0;
          res_next.event_res = msld_pkg::EV_ABORT;
        end else begin
          byte_position_next     = pos_inc;
          res_next.event_res     = msld_pkg::EV_PAYLOAD;
          res_next.data_byte     = rx_byte;
          res_next.last_of_frame = ({1'b0, pos_inc} >= length_word);
          if (res_next.last_of_frame) begin
            phase_next = PH_HUNT;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (hit) begin
          phase_next         = PH_LEN;
          byte_position_next = 31'd0;
        end
      end
    endcase
    if (!step) begin
      phase_next         = phase;
      length_word_next   = length_word;
      byte_position_next = byte_position;
      res_next.valid     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      length_word   <= 32'd0;
      byte_position <= 31'd0;
    end else begin
      phase         <= phase_next;
      length_word   <= length_word_next;
      byte_position <= byte_position_next;
    end
  end

  assign res = res_next;

endmodule

[hdl/msld_out_buf.sv]
// ----------------------------------------------------------------------------
// msld_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module msld_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  msld_pkg::result_t  res,
  output logic               room,
  msld_res_if.source         out
);

  msld_pkg::result_t main_q;
  msld_pkg::result_t skid_q;
  logic              pop;

  assign pop  = main_q.valid && out.ready;
  assign room = !skid_q.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_q.valid <= 1'b0;
      skid_q.valid <= 1'b0;
    end else if (pop) begin
      if (skid_q.valid) begin
        main_q       <= skid_q;
        skid_q.valid <= 1'b0;
      end else if (res.valid) begin
        main_q <= res;
      end else begin
        main_q.valid <= 1'b0;
      end
    end else if (res.valid) begin
      if (main_q.valid) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

  assign out.valid         = main_q.valid;
  assign out.event_res     = main_q.event_res;
  assign out.data_byte     = main_q.data_byte;
  assign out.last_of_frame = main_q.last_of_frame;
  assign out.frame_length  = $signed(main_q.frame_length);

endmodule

[hdl/magic_sync_length_deframer_core.sv]
// ----------------------------------------------------------------------------
// magic_sync_length_deframer_core
// Sync-word hunt, little-endian length field and payload pass-through.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the result buffer has room; each
// result word is registered in the output buffer on its way out. The window
// is a row of eight byte cells that shift in step and each compare one byte
// of the sync pattern, so the match is known in the same cycle as the byte.
// Results pass through a two-entry buffer, so rx stays ready while one result
// waits; rx drops ready only when both entries are held. Register writes are
// always taken and should be made while the block is idle.
module magic_sync_length_deframer_core (
  input  logic          clk,
  input  logic          rst,
  msld_byte_if.sink     rx,
  msld_res_if.source    res,
  msld_cfg_if.sink      cfg
);

  logic [63:0] sync_pattern;
  logic [30:0] max_frame_length;
  logic        step;
  logic        room;
  logic [7:0]  cell_byte [msld_pkg::WINDOW_BYTES];
  logic [msld_pkg::WINDOW_BYTES-1:0] cell_match;
  msld_pkg::result_t ctrl_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern     <= 64'd0;
      max_frame_length <= msld_pkg::MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == msld_pkg::CFG_SYNC_PATTERN) begin
        sync_pattern <= cfg.data;
      end else if (cfg.index == msld_pkg::CFG_MAX_LENGTH) begin
        max_frame_length <= cfg.data[30:0];
      end
    end
  end

  assign rx.ready = room;
  assign step     = rx.valid && room;

  for (genvar i = 0; i < msld_pkg::WINDOW_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      msld_sync_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .shift        (step),
        .byte_in      (rx.rx_byte),
        .pattern_byte (sync_pattern[8*i +: 8]),
        .byte_out     (cell_byte[i]),
        .match        (cell_match[i])
      );
    end else begin : g_body
      msld_sync_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .shift        (step),
        .byte_in      (cell_byte[i-1]),
        .pattern_byte (sync_pattern[8*i +: 8]),
        .byte_out     (cell_byte[i]),
        .match        (cell_match[i])
      );
    end
  end

  msld_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .rx_byte          (rx.rx_byte),
    .hit              (&cell_match),
    .max_frame_length (max_frame_length),
    .res              (ctrl_res)
  );

  msld_out_buf u_out_buf (
    .clk  (clk),
    .rst  (rst),
    .res  (ctrl_res),
    .room (room),
    .out  (res)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream testbench for the sync-word, length-prefixed deframer. A short
// scripted run walks hunt, length and payload through their corner values,
// then randomized frames with random content run under several register
// settings. Every output word is checked field by field against a scripted
// expected word or an in-bench model of the deframer, with random gaps on
// both channels and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] CFG_SPARE_IDX   = 2'd3;
  localparam int         SETTLE_CYCLES   = 4;
  localparam int         DRAIN_CYCLES    = 16;
  localparam int         HOLD_OFF_CYCLES = 64;
  localparam int         PHASE_BYTES     = 250;
  localparam int         RAND_PHASES     = 7;
  localparam longint     RUN_LIMIT_NS    = 64'd10_000_000;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } deframe_phase_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [7:0]  data;
    logic        last;
    logic [31:0] flen;
  } deframe_word_t;

  typedef struct packed {
    logic          write_reg;
    logic [1:0]    reg_index;
    logic [63:0]   value;
    logic          typed;
    deframe_word_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  msld_byte_if rx_ch ();
  msld_res_if  res_ch ();
  msld_cfg_if  cfg_ch ();

  magic_sync_length_deframer_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // deframer model state
  logic [63:0]    sync_cfg;
  logic [30:0]    max_len_cfg;
  deframe_phase_t cur_phase;
  logic [63:0]    win;
  logic [31:0]    len_word;
  logic [30:0]    pos;

  deframe_word_t  pending_words [$];
  int             mismatches = 0;
  int             bytes_sent = 0;
  bit             steady = 1'b0;
  int             squeeze_asks = 0;
  int             squeezes_done = 0;

  logic           row_typed = 1'b0;
  deframe_word_t  row_word = '0;

  function automatic bit deframe_byte(input logic [7:0] b, output deframe_word_t word);
    logic hit;
    bit   produced;
    produced = 1'b0;
    word = '0;
    win = {win[55:0], b};
    hit = (win == sync_cfg);
    case (cur_phase)
      PH_LENGTH: begin
        if (hit) begin
          pos = '0;
        end else begin
          len_word[pos[1:0]*8 +: 8] = b;
          pos = pos + 31'd1;
          if (pos >= 31'(msld_pkg::LEN_BYTES)) begin
            if (len_word[31] || len_word == 32'd0 || len_word[30:0] > max_len_cfg) begin
              cur_phase = PH_HUNT;
              word = '{msld_pkg::EV_REJECT, 8'h00, 1'b0, len_word};
              produced = 1'b1;
            end else begin
              cur_phase = PH_PAYLOAD;
              pos = '0;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (hit) begin
          cur_phase = PH_LENGTH;
          pos = '0;
          word = '{msld_pkg::EV_ABORT, 8'h00, 1'b0, len_word};
        end else begin
          pos = pos + 31'd1;
          word = '{msld_pkg::EV_PAYLOAD, b, ({1'b0, pos} >= len_word), len_word};
          if (word.last) cur_phase = PH_HUNT;
        end
        produced = 1'b1;
      end
      default: begin
        cur_phase = PH_HUNT;
        if (hit) begin
          cur_phase = PH_LENGTH;
          pos = '0;
        end
      end
    endcase
    return produced;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  deframe_word_t mon_word;
  deframe_word_t mon_want;

  always @(posedge clk) begin
    if (rst) begin
      sync_cfg    = '0;
      max_len_cfg = msld_pkg::MAX_LENGTH_RESET;
      cur_phase   = PH_HUNT;
      win         = '0;
      len_word    = '0;
      pos         = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          msld_pkg::CFG_SYNC_PATTERN: sync_cfg = cfg_ch.data;
          msld_pkg::CFG_MAX_LENGTH:   max_len_cfg = cfg_ch.data[30:0];
          default: ;
        endcase
      end
      if (rx_ch.valid && rx_ch.ready) begin
        if (row_typed) begin
          void'(deframe_byte(rx_ch.rx_byte, mon_word));
          pending_words.push_back(row_word);
        end else if (deframe_byte(rx_ch.rx_byte, mon_word)) begin
          pending_words.push_back(mon_word);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: event_res %0d data_byte %0h", res_ch.event_res,
                 res_ch.data_byte);
          mismatches++;
        end else begin
          mon_want = pending_words.pop_front();
          compare_field("event_res", 32'(mon_want.ev), 32'(res_ch.event_res));
          compare_field("data_byte", 32'(mon_want.data), 32'(res_ch.data_byte));
          compare_field("last_of_frame", 32'(mon_want.last), 32'(res_ch.last_of_frame));
          compare_field("frame_length", mon_want.flen, res_ch.frame_length);
        end
      end
    end
  end

  // output side: random stalls, plus the long hold-off on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_asks != squeezes_done) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        squeezes_done++;
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!steady && r < 10) stall_left = $urandom_range(1, 3);
        else if (!steady && r < 12) stall_left = $urandom_range(10, 40);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input deframe_word_t want);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (steady || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    repeat (gap) begin
      @(negedge clk);
      rx_ch.valid = 1'b0;
    end
    @(negedge clk);
    row_typed = typed;
    row_word = want;
    rx_ch.rx_byte = b;
    rx_ch.valid = 1'b1;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic send_sync();
    for (int i = msld_pkg::WINDOW_BYTES - 1; i >= 0; i--) send_plain(sync_cfg[i*8 +: 8]);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] v);
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = v;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_frame();
    int          r;
    int          cap;
    int          k;
    int          rounds;
    bit          aborted;
    bit          accepted;
    logic [31:0] flen;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) send_plain(8'($urandom_range(0, 255)));
      return;
    end
    send_sync();
    // a periodic pattern re-syncs while the length is collected
    if (sync_cfg == {8{sync_cfg[7:0]}} && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_plain(sync_cfg[7:0]);
    rounds = 0;
    do begin
      aborted = 1'b0;
      r = $urandom_range(0, 99);
      cap = ($urandom_range(0, 9) == 0) ? 120 : 16;
      if (max_len_cfg == 0 || r >= 75) begin
        if (r < 83) flen = 32'd0;
        else if (r < 92) flen = $urandom() | 32'h8000_0000;
        else flen = {1'b0, max_len_cfg} + 32'd1 + 32'($urandom_range(0, 1000));
      end else begin
        flen = 32'($urandom_range(1, (max_len_cfg < 31'(cap)) ? int'(max_len_cfg) : cap));
      end
      for (int i = 0; i < msld_pkg::LEN_BYTES; i++) send_plain(flen[i*8 +: 8]);
      accepted = !(flen[31] || flen == 32'd0 || flen[30:0] > max_len_cfg);
      if (accepted) begin
        if (rounds == 0 && flen >= 32'd9 && $urandom_range(0, 7) == 0) begin
          k = $urandom_range(0, int'(flen) - 9);
          repeat (k) send_plain(8'($urandom_range(0, 255)));
          send_sync();
          aborted = 1'b1;
        end else begin
          repeat (int'(flen)) send_plain(8'($urandom_range(0, 255)));
        end
      end
      rounds++;
    end while (aborted);
  endtask

  function automatic stim_row_t byte_row(input logic [7:0] b);
    return '{1'b0, 2'd0, {56'd0, b}, 1'b0, deframe_word_t'('0)};
  endfunction

  function automatic stim_row_t check_row(input logic [7:0] b, input logic [1:0] ev,
                                          input logic [7:0] d, input logic last,
                                          input logic [31:0] flen);
    return '{1'b0, 2'd0, {56'd0, b}, 1'b1, deframe_word_t'({ev, d, last, flen})};
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [63:0] v);
    return '{1'b1, idx, v, 1'b0, deframe_word_t'('0)};
  endfunction

  stim_row_t script [32];

  initial begin
    logic [63:0] max_data;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = msld_pkg::CFG_SYNC_PATTERN;
    cfg_ch.data = 64'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    script = '{
      byte_row(8'h00),
      byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF),
      check_row(8'hFF, msld_pkg::EV_REJECT, 8'h00, 1'b0, 32'hFFFF_FFFF),
      reg_row(msld_pkg::CFG_SYNC_PATTERN, 64'h0000_00FF_FFFF_FF5A),
      reg_row(msld_pkg::CFG_MAX_LENGTH, 64'h0000_0000_7FFF_FFFF),
      byte_row(8'h5A),
      byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF), byte_row(8'h7F),
      byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF), byte_row(8'hFF),
      check_row(8'h5A, msld_pkg::EV_ABORT, 8'h00, 1'b0, 32'h7FFF_FFFF),
      byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      check_row(8'h00, msld_pkg::EV_REJECT, 8'h00, 1'b0, 32'h0000_0000),
      reg_row(msld_pkg::CFG_SYNC_PATTERN, 64'hFFFF_5A00_0000_0001),
      reg_row(msld_pkg::CFG_MAX_LENGTH, 64'd1),
      byte_row(8'h01),
      byte_row(8'h01), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
      check_row(8'hC3, msld_pkg::EV_PAYLOAD, 8'hC3, 1'b1, 32'd1)
    };

    foreach (script[i]) begin
      if (script[i].write_reg) write_register(script[i].reg_index, script[i].value);
      else send_byte(script[i].value[7:0], script[i].typed, script[i].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, {$urandom(), $urandom()});
          max_data = {$urandom(), 1'b0, 31'($urandom_range(1, 40))};
        end
        1: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, {$urandom(), $urandom()});
          max_data = '1;
        end
        2: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, 64'd0);
          max_data = 64'h0000_0000_8000_0000;
        end
        3: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, '1);
          max_data = 64'd1;
        end
        4: begin
          write_register(CFG_SPARE_IDX, {$urandom(), $urandom()});
          write_register(msld_pkg::CFG_SYNC_PATTERN, {$urandom(), $urandom()});
          max_data = 64'($urandom_range(1, 300));
        end
        5: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, {8{8'($urandom_range(0, 255))}});
          max_data = 64'($urandom_range(1, 64));
        end
        default: begin
          write_register(msld_pkg::CFG_SYNC_PATTERN, {$urandom(), $urandom()});
          max_data = {32'd0, 1'b0, 31'($urandom())};
        end
      endcase
      write_register(msld_pkg::CFG_MAX_LENGTH, max_data);
      steady = (p == 1);
      if (p == 1) squeeze_asks++;
      k_loop: begin
        int budget;
        budget = bytes_sent + PHASE_BYTES;
        while (bytes_sent < budget) send_frame();
      end
    end

    @(negedge clk);
    rx_ch.valid = 1'b0;
    steady = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
